// ===== src/crcbs_pkg.sv =====
package crcbs_pkg;

   localparam int unsigned CrcWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned RomDepth = 256;
   localparam logic [CrcWidth-1:0] CrcPoly = 32'hedb8_8320;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 first_byte;
      logic [CrcWidth-1:0]  seed_value;
      logic                 last_byte;
   } crc_req_type;

   typedef struct packed {
      logic [CrcWidth-1:0] crc_value;
      logic                crc_done;
   } crc_rsp_type;

   function automatic logic [CrcWidth-1:0] byte_reverse(input logic [CrcWidth-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // One table entry: the reflected CRC of the index byte, byte-swapped.
   function automatic logic [CrcWidth-1:0] rom_entry(input logic [ByteWidth-1:0] idx);
      logic [CrcWidth-1:0] acc;
      acc = {{(CrcWidth-ByteWidth){1'b0}}, idx};
      for (int k = 0; k < ByteWidth; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CrcPoly;
         end else begin
            acc = acc >> 1;
         end
      end
      return byte_reverse(acc);
   endfunction

endpackage

// ===== src/crc32_byte_swapped_engine.sv =====
// Byte-serial Ethernet CRC-32 (reflected polynomial 0xEDB88320) whose running value is
// kept with its four bytes swapped. Each request word carries one data byte; with
// first_byte set the fold starts from seed_value, otherwise from the previous result
// (zero after reset). Every request gives exactly one response word holding the updated
// CRC and an echo of last_byte; no final XOR is applied. One byte is taken per clock
// while the response side does not stall: a word first waits in the input register,
// where a 256-entry constant ROM lookup and one XOR produce the new value, and then
// in the output register.
module crc32_byte_swapped_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  crcbs_pkg::crc_req_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crcbs_pkg::crc_rsp_type rsp_word
);
   import crcbs_pkg::*;

   logic        hold_valid;
   crc_req_type hold_word;
   crc_rsp_type fold_word;
   logic        load_ready;
   logic        advance;

   assign advance = hold_valid & load_ready;

   crcbs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   crcbs_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .commit    (advance),
      .hold_word (hold_word),
      .fold_word (fold_word)
   );

   crcbs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (hold_valid),
      .load_ready (load_ready),
      .load_word  (fold_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== src/crcbs_in_reg.sv =====
module crcbs_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  crcbs_pkg::crc_req_type req_word,
   input  logic                advance,
   output logic                hold_valid,
   output crcbs_pkg::crc_req_type hold_word
);
   import crcbs_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   crc_req_type word_ff;

   // The held word leaves whenever the fold stage takes it.
   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         word_ff <= req_word;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

endmodule

// ===== src/crcbs_fold.sv =====
module crcbs_fold (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    commit,
   input  crcbs_pkg::crc_req_type  hold_word,
   output crcbs_pkg::crc_rsp_type  fold_word
);
   import crcbs_pkg::*;

   logic [CrcWidth-1:0]  running_ff;
   logic [CrcWidth-1:0]  running_in;
   logic [CrcWidth-1:0]  start_crc;
   logic [ByteWidth-1:0] rom_index;
   logic [CrcWidth-1:0]  rom_table [RomDepth];

   // Every entry is a constant, so the table reduces to fixed logic.
   for (genvar g = 0; g < RomDepth; g++) begin : g_rom
      assign rom_table[g] = rom_entry(ByteWidth'(g));
   end

   assign start_crc  = hold_word.first_byte ? hold_word.seed_value : running_ff;
   assign rom_index  = start_crc[CrcWidth-1 -: ByteWidth] ^ hold_word.data_byte;
   assign running_in = {start_crc[CrcWidth-ByteWidth-1:0], {ByteWidth{1'b0}}}
                       ^ rom_table[rom_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else if (commit) begin
         running_ff <= running_in;
      end
   end

   assign fold_word.crc_value = running_in;
   assign fold_word.crc_done  = hold_word.last_byte;

endmodule

// ===== src/crcbs_out_reg.sv =====
module crcbs_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   output logic                   load_ready,
   input  crcbs_pkg::crc_rsp_type load_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crcbs_pkg::crc_rsp_type rsp_word
);
   import crcbs_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   crc_rsp_type word_ff;

   assign load_ready = ~valid_ff | ~rsp_stall;
   assign valid_in   = load_ready ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== src/crcbs_checker.sv =====
module crcbs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input crcbs_pkg::crc_req_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input crcbs_pkg::crc_rsp_type rsp_word
);
   import crcbs_pkg::*;

   // Nothing is left to deliver right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // With the output register empty the input side never pushes back.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output register is empty");

   // A word accepted while no response is pending comes out through the input and output registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_word)))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response changed");

endmodule

bind crc32_byte_swapped_engine crcbs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ===== tb/tb_crc32_byte_swapped_engine.sv =====
`timescale 1ns / 100ps

module tb_crc32_byte_swapped_engine;
   import crcbs_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned RandomWords = 540;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   crc_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   crc_rsp_type rsp_word;

   crc_rsp_type pending_crcs[$];
   logic [CrcWidth-1:0] model_crc = '0;
   int error_count = 0;
   int unsigned cycle_count = 0;
   bit send_gaps_on = 1'b1;
   bit recv_gaps_on = 1'b1;
   int long_hold_cycles = 0;

   crc32_byte_swapped_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Reflected CRC-32 of one index byte, returned with its bytes in reverse order.
   function automatic logic [CrcWidth-1:0] swapped_table_entry(input logic [7:0] idx);
      logic [CrcWidth-1:0] rem;
      logic [CrcWidth-1:0] swapped;
      rem = {24'h0, idx};
      for (int k = 0; k < 8; k++) begin
         rem = rem[0] ? ((rem >> 1) ^ CrcPoly) : (rem >> 1);
      end
      for (int b = 0; b < 4; b++) begin
         swapped[8*b +: 8] = rem[8*(3-b) +: 8];
      end
      return swapped;
   endfunction

   function automatic logic [CrcWidth-1:0] fold_byte(input logic [CrcWidth-1:0] crc,
                                                      input logic [7:0] data);
      return (crc << 8) ^ swapped_table_entry(crc[31:24] ^ data);
   endfunction

   function automatic crc_req_type make_word(input logic [7:0] data, input bit is_first,
                                             input logic [31:0] seed, input bit is_last);
      crc_req_type w;
      w.data_byte = data;
      w.first_byte = is_first;
      w.seed_value = seed;
      w.last_byte = is_last;
      return w;
   endfunction

   // Input monitor feeds the CRC model; output monitor checks against the oldest prediction.
   always @(posedge clock) begin : word_monitor
      crc_rsp_type want;
      logic [CrcWidth-1:0] base;
      if (!reset && req_valid && !req_stall) begin
         base = req_word.first_byte ? req_word.seed_value : model_crc;
         model_crc = fold_byte(base, req_word.data_byte);
         want.crc_value = model_crc;
         want.crc_done = req_word.last_byte;
         pending_crcs.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_crcs.size() == 0) begin
            $error("unexpected response word: crc_value %h crc_done %b",
                   rsp_word.crc_value, rsp_word.crc_done);
            error_count++;
         end else begin
            want = pending_crcs.pop_front();
            if (rsp_word.crc_value !== want.crc_value) begin
               $error("crc_value: expected %h, got %h", want.crc_value, rsp_word.crc_value);
               error_count++;
            end
            if (rsp_word.crc_done !== want.crc_done) begin
               $error("crc_done: expected %b, got %b", want.crc_done, rsp_word.crc_done);
               error_count++;
            end
         end
      end
   end

   initial begin : response_sink
      int wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_cycles > 0) begin
            wait_cycles = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            wait_cycles = recv_gaps_on ? $urandom_range(0, 3) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_word(input crc_req_type w);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic release_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Without any seeded word the fold starts from the reset value of zero.
   task automatic test_fold_from_reset();
      send_word(make_word(8'h00, 1'b0, $urandom, 1'b0));
      send_word(make_word(8'hff, 1'b0, $urandom, 1'b1));
   endtask

   task automatic test_data_extremes();
      send_word(make_word(8'h00, 1'b1, 32'hffff_ffff, 1'b0));
      send_word(make_word(8'hff, 1'b0, 32'h0000_0000, 1'b0));
      send_word(make_word(8'h55, 1'b0, 32'hffff_ffff, 1'b0));
      send_word(make_word(8'haa, 1'b0, 32'h0000_0000, 1'b1));
   endtask

   task automatic test_seed_extremes();
      send_word(make_word(8'h3c, 1'b1, 32'h0000_0000, 1'b1));
      send_word(make_word(8'hc3, 1'b1, 32'hffff_ffff, 1'b1));
      send_word(make_word(8'h00, 1'b1, 32'ha5a5_5a5a, 1'b1));
   endtask

   // The seed field carries noise that must have no effect on unseeded words.
   task automatic test_seed_ignored();
      send_word(make_word(8'h12, 1'b0, 32'hffff_ffff, 1'b0));
      send_word(make_word(8'h34, 1'b0, 32'h0000_0000, 1'b0));
      send_word(make_word(8'h56, 1'b0, 32'h5a5a_a5a5, 1'b1));
   endtask

   task automatic test_fold_past_last();
      send_word(make_word(8'h01, 1'b1, 32'h1234_5678, 1'b1));
      send_word(make_word(8'h02, 1'b0, 32'h0, 1'b0));
      send_word(make_word(8'h80, 1'b0, 32'h0, 1'b1));
   endtask

   task automatic test_check_string();
      byte unsigned msg[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      for (int i = 0; i < 9; i++) begin
         send_word(make_word(msg[i], i == 0, 32'hffff_ffff, i == 8));
      end
   endtask

   // Mostly well-formed packets with random content, some words with random flags.
   task automatic test_random_packets();
      int sent;
      int len;
      logic [31:0] seed;
      sent = 0;
      while (sent < RandomWords) begin
         if ($urandom_range(0, 5) == 0) begin
            send_gaps_on = 1'($urandom_range(0, 1));
            recv_gaps_on = 1'($urandom_range(0, 1));
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
         seed = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 6) == 0) begin
               send_word(make_word(8'($urandom), 1'($urandom_range(0, 1)), $urandom,
                                   1'($urandom_range(0, 1))));
            end else begin
               send_word(make_word(8'($urandom), i == 0, (i == 0) ? seed : $urandom,
                                   i == len - 1));
            end
         end
         sent += len;
      end
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
   endtask

   // The sink holds off long enough for the engine to fill and stall its input.
   task automatic test_output_backpressure();
      send_gaps_on = 1'b0;
      long_hold_cycles = 60;
      for (int i = 0; i < 40; i++) begin
         send_word(make_word(8'($urandom), i == 0, $urandom, i == 39));
      end
      send_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fold_from_reset();
      test_data_extremes();
      test_seed_extremes();
      test_seed_ignored();
      test_fold_past_last();
      test_check_string();
      test_output_backpressure();
      test_random_packets();
      release_input();
      while (pending_crcs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
